// ===== sv/fnta_pkg.sv =====
// shared types, codes and character constants of the number formatter
package fnta_pkg;

   // format codes carried in the request tuser
   localparam logic [1:0] FMT_UDEC = 2'd0;
   localparam logic [1:0] FMT_SDEC = 2'd1;
   localparam logic [1:0] FMT_HEX  = 2'd2;
   localparam logic [1:0] FMT_BIN  = 2'd3;

   // ascii codes
   localparam logic [6:0] ASC_ZERO  = 7'h30;
   localparam logic [6:0] ASC_A     = 7'h41;
   localparam logic [6:0] ASC_PLUS  = 7'h2B;
   localparam logic [6:0] ASC_MINUS = 7'h2D;

   // field widths
   localparam int NUMBER_W = 32;
   localparam int COUNT_W  = 6;
   localparam int LINE_W   = 3;
   localparam int SCOL_W   = 5;
   localparam int COL_W    = 6;
   localparam int CHAR_W   = 7;
   localparam logic [COUNT_W-1:0] MAX_DIGITS = 6'd32;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_sign;
      logic emit_digit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dec;
      logic is_signed;
      logic count_zero;
      logic rem_one;
      logic conv_last;
      logic out_free;
   } dp_status_type;

   // digit value to ascii character
   function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = ASC_ZERO + {3'b000, d};
      end else begin
         c = ASC_A + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

// ===== sv/fnta_ctrl.sv =====
// controller state machine of the number formatter
module fnta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fnta_pkg::dp_status_type status,
   output fnta_pkg::dp_cmd_type    cmd
);
   import fnta_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.is_dec) begin
               state_in = ST_CONVERT;
            end else if (status.count_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               if (status.is_signed) begin
                  state_in = ST_SIGN;
               end else if (status.count_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = status.count_zero ? ST_IDLE : ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.rem_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/fnta_datapath.sv =====
// datapath: operand registers, bcd conversion, digit select and output register
module fnta_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fnta_pkg::dp_cmd_type                 cmd,
   output fnta_pkg::dp_status_type              status,
   input  logic [1:0]                          in_command,
   input  logic [fnta_pkg::NUMBER_W-1:0]       in_number,
   input  logic [fnta_pkg::COUNT_W-1:0]        in_digit_count,
   input  logic [fnta_pkg::LINE_W-1:0]         in_text_line,
   input  logic [fnta_pkg::SCOL_W-1:0]         in_start_column,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [fnta_pkg::CHAR_W-1:0]         out_char,
   output logic [fnta_pkg::LINE_W-1:0]         out_line,
   output logic [fnta_pkg::COL_W-1:0]          out_column,
   output logic                                out_last
);
   import fnta_pkg::*;

   // decimal digits that a VALUE_BITS value can need
   localparam int NDEC  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W = 4 * NDEC;
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [1:0]            fmt_ff, fmt_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] sh_ff, sh_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [LINE_W-1:0]     line_ff, line_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  ovalid_ff, ovalid_in;
   logic [CHAR_W-1:0]     och_ff, och_in;
   logic [LINE_W-1:0]     oline_ff, oline_in;
   logic [COL_W-1:0]      ocol_ff, ocol_in;
   logic                  olast_ff, olast_in;

   logic [VALUE_BITS-1:0] raw_val;
   logic [BCD_W-1:0]      bcd_adj;
   logic [4:0]            pos;
   logic [3:0]            digit;

   assign raw_val = VALUE_BITS'(in_number);
   assign pos     = rem_ff[4:0] - 5'd1;

   // add-three correction on each bcd digit before the shift
   always_comb begin
      for (int k = 0; k < NDEC; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // digit at the current position; weights beyond the value give zero
   always_comb begin
      case (fmt_ff)
         FMT_HEX: digit = 4'(val_ff >> {pos, 2'b00});
         FMT_BIN: digit = {3'b000, 1'(val_ff >> pos)};
         default: digit = 4'(bcd_ff >> {pos, 2'b00});
      endcase
   end

   // operand and conversion registers
   always_comb begin
      fmt_in  = fmt_ff;
      val_in  = val_ff;
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      line_in = line_ff;
      col_in  = col_ff;
      if (cmd.load) begin
         fmt_in  = in_command;
         neg_in  = (in_command == FMT_SDEC) && raw_val[VALUE_BITS-1];
         val_in  = raw_val;
         sh_in   = neg_in ? (~raw_val + 1'b1) : raw_val;
         bcd_in  = '0;
         cnt_in  = '0;
         rem_in  = (in_digit_count > MAX_DIGITS) ? MAX_DIGITS : in_digit_count;
         line_in = in_text_line;
         col_in  = {1'b0, in_start_column};
      end else if (cmd.conv_step) begin
         bcd_in = {bcd_adj[BCD_W-2:0], sh_ff[VALUE_BITS-1]};
         sh_in  = {sh_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.emit_sign) begin
         col_in = col_ff + 6'd1;
      end else if (cmd.emit_digit) begin
         col_in = col_ff + 6'd1;
         rem_in = rem_ff - 6'd1;
      end
   end

   // output register, refilled as the consumer takes a transaction
   always_comb begin
      och_in    = och_ff;
      oline_in  = oline_ff;
      ocol_in   = ocol_ff;
      olast_in  = olast_ff;
      ovalid_in = ovalid_ff && !out_ready;
      if (cmd.emit_sign) begin
         och_in    = neg_ff ? ASC_MINUS : ASC_PLUS;
         oline_in  = line_ff;
         ocol_in   = col_ff;
         olast_in  = (rem_ff == '0);
         ovalid_in = 1'b1;
      end else if (cmd.emit_digit) begin
         och_in    = digit_to_ascii(digit);
         oline_in  = line_ff;
         ocol_in   = col_ff;
         olast_in  = (rem_ff == 6'd1);
         ovalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff   <= fmt_in;
      val_ff   <= val_in;
      sh_ff    <= sh_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      line_ff  <= line_in;
      col_ff   <= col_in;
      och_ff   <= och_in;
      oline_ff <= oline_in;
      ocol_ff  <= ocol_in;
      olast_ff <= olast_in;
   end

   // status back to the controller
   assign status.is_dec     = (fmt_ff == FMT_UDEC) || (fmt_ff == FMT_SDEC);
   assign status.is_signed  = (fmt_ff == FMT_SDEC);
   assign status.count_zero = (rem_ff == '0);
   assign status.rem_one    = (rem_ff == 6'd1);
   assign status.conv_last  = (cnt_ff == CNT_W'(VALUE_BITS - 1));
   assign status.out_free   = !ovalid_ff || out_ready;

   assign out_valid  = ovalid_ff;
   assign out_char   = och_ff;
   assign out_line   = oline_ff;
   assign out_column = ocol_ff;
   assign out_last   = olast_ff;

endmodule

// ===== sv/fixed_width_number_to_ascii_top.sv =====
// top level of the fixed-width number to ascii formatter
// conversion: decimal formats run one double-dabble shift per value bit before
// the first character; hex and binary go from the start state straight to the digits
// throughput: one character per cycle once characters flow, while rsp_tready is high;
// a new number is taken only after the last character of the previous one is issued
// reset: synchronous active-high, empties the output register and idles the fsm
module fixed_width_number_to_ascii_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // number[31:0], digit_count[37:32], text_line[40:38], start_column[45:41], zero pad
   input  logic [47:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ascii_char[6:0], out_line[9:7], out_column[15:10]
   output logic [15:0] rsp_tdata,
   // last_char
   output logic        rsp_tlast
);
   import fnta_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [CHAR_W-1:0] ch;
   logic [LINE_W-1:0] line;
   logic [COL_W-1:0]  col;

   // sequencer
   fnta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   fnta_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_command      (req_tuser),
      .in_number       (req_tdata[31:0]),
      .in_digit_count  (req_tdata[37:32]),
      .in_text_line    (req_tdata[40:38]),
      .in_start_column (req_tdata[45:41]),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_char        (ch),
      .out_line        (line),
      .out_column      (col),
      .out_last        (rsp_tlast)
   );

   assign rsp_tdata = {col, line, ch};

endmodule

// ===== sv/fnta_checker.sv =====
// port-level checker of the number formatter and its bind
module fnta_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   import fnta_pkg::*;

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // no character right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a pending non-final character means the number is still in progress
   a_busy_mid_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a number");

   // accepted transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

endmodule

bind fixed_width_number_to_ascii_top fnta_checker u_fnta_checker (.*);
